### design/wpd_pkg.sv
// shared types and constants of the waveform peak decimator
`default_nettype none

package wpd_pkg;

	// sample format codes
	localparam logic [1:0] FMT_S16 = 2'd0;
	localparam logic [1:0] FMT_F32 = 2'd1;
	localparam logic [1:0] FMT_S8  = 2'd2;
	localparam logic [1:0] FMT_U8  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_FORMAT   = 2'd0;
	localparam logic [1:0] REG_CHANNELS = 2'd1;
	localparam logic [1:0] REG_FRAMES   = 2'd2;

	// fixed field widths
	localparam int FMT_W      = 2;
	localparam int CHAN_W     = 4;
	localparam int FRAME_W    = 32;
	localparam int SAMPLE_W   = 32;
	localparam int Q15_W      = 16;
	localparam int BUCKET_W   = 12;
	localparam int DVD_W      = 32;
	localparam int DIV_STEP_W = 6;

	// divider request
	typedef struct packed {
		logic                  start;
		logic [DIV_STEP_W-1:0] steps;
	} div_ctl_t;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

`default_nettype wire

### design/wpd_norm.sv
// sample normaliser: raw pcm bits to signed q1.15
`default_nettype none

module wpd_norm (
	input  wire logic [wpd_pkg::FMT_W-1:0]    fmt,
	input  wire logic [wpd_pkg::SAMPLE_W-1:0] bits,
	output logic signed [wpd_pkg::Q15_W-1:0]  q15
);
	import wpd_pkg::*;

	logic        f_neg;
	logic [7:0]  f_exp;
	logic [22:0] f_man;
	logic [23:0] f_mag;
	logic [4:0]  f_sh;
	logic [15:0] f_val;

	// float32 to q1.15, truncating, saturating at one
	always_comb begin
		f_neg = bits[31];
		f_exp = bits[30:23];
		f_man = bits[22:0];
		f_sh  = 5'(8'd135 - f_exp);
		f_mag = {1'b1, f_man} >> f_sh;
		if (f_exp == 8'hff && f_man != 23'd0) begin
			f_val = 16'd0;
		end else if (f_exp >= 8'd127) begin
			f_val = f_neg ? 16'h8000 : 16'h7fff;
		end else if (f_exp <= 8'd111) begin
			f_val = 16'd0;
		end else begin
			f_val = f_neg ? 16'(-f_mag) : f_mag[15:0];
		end
	end

	// format select
	always_comb begin
		unique case (fmt)
			FMT_S16: q15 = signed'(bits[15:0]);
			FMT_F32: q15 = signed'(f_val);
			FMT_S8:  q15 = signed'({bits[7:0], 8'd0});
			FMT_U8:  q15 = signed'({~bits[7], bits[6:0], 8'd0});
			default: q15 = '0;
		endcase
	end

endmodule

`default_nettype wire

### design/wpd_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module wpd_div #(
	parameter int DVS_W = 13
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire wpd_pkg::div_ctl_t          ctl,
	input  wire logic [wpd_pkg::DVD_W-1:0]  dividend,
	input  wire logic [DVS_W-1:0]           divisor,
	output wpd_pkg::div_sts_t               sts,
	output logic [wpd_pkg::DVD_W-1:0]       quotient,
	output logic [DVS_W-1:0]                remainder
);
	import wpd_pkg::*;

	logic [DVS_W-1:0]      rem_q;
	logic [DVD_W-1:0]      quo_q;
	logic [DVS_W-1:0]      dvs_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DVS_W:0]        trial;
	logic [DVS_W:0]        diff;
	logic                  fits;

	// one trial subtract
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ctl.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// partial remainder and quotient
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

### design/waveform_peak_decimator_top.sv
// peak-hold waveform decimator top level: sequencer, state and output register
//
//  channel  dir  handshake                  payload
//  s_*      in   s_tvalid / s_tready        s_tdata: sample_bits
//  m_*      out  m_tvalid / m_tready        m_tdata: peak_value, bucket_number; m_tlast
//  cfg_*    in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// a sample that does not close a frame leaves s_tready high
// a frame-closing sample holds s_tready low through S_MIX, S_DIV and S_PEAK, with the shared
// divider producing one quotient bit per cycle, and through S_EMIT when a bucket closes
// a write to the format, channels or frames register restarts the clip; when frame_total is
// nonzero, frame_total / bucket count is then computed on the same divider with s_tready low
// a finished peak waits in the output register; a further bucket end waits
// for it to be taken
`default_nettype none

module waveform_peak_decimator_top #(
	parameter int MAX_POINTS   = 4096,
	parameter int MAX_CHANNELS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// sample beats
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] sample_bits
	// peak beats
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [15:0] peak_value, [27:16] bucket_number, zero above
	output logic             m_tlast,   // last_bucket
	// register writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import wpd_pkg::*;

	localparam int N_W     = $clog2(MAX_POINTS + 1);
	localparam int EFF_MAX = (MAX_CHANNELS < 15) ? MAX_CHANNELS : 15;
	localparam int SUM_W   = Q15_W + $clog2(EFF_MAX);
	localparam int DV_W    = (N_W > CHAN_W) ? N_W : CHAN_W;
	localparam logic [FRAME_W-1:0] MAXP = FRAME_W'(MAX_POINTS);

	typedef enum logic [6:0] {
		S_START = 7'b0000001,
		S_SETUP = 7'b0000010,
		S_IDLE  = 7'b0000100,
		S_MIX   = 7'b0001000,
		S_DIV   = 7'b0010000,
		S_PEAK  = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;

	// registers
	logic [FMT_W-1:0]   fmt_q;
	logic [CHAN_W-1:0]  chan_q;
	logic [FRAME_W-1:0] total_q;

	// clip state
	logic [N_W-1:0]            idx_q;
	logic [FRAME_W-1:0]        frame_q;
	logic [FRAME_W-1:0]        end_q;
	logic [N_W-1:0]            frac_q;
	logic [FRAME_W-1:0]        tq_q;
	logic [N_W-1:0]            tr_q;
	logic [CHAN_W-1:0]         cnt_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [Q15_W-1:0]   peak_q;
	logic [Q15_W:0]            pmag_q;

	// output register
	logic                    out_valid_q;
	logic signed [Q15_W-1:0] out_peak_q;
	logic [BUCKET_W-1:0]     out_bnum_q;
	logic                    out_last_q;

	// datapath signals
	logic signed [Q15_W-1:0] norm;
	logic signed [SUM_W-1:0] sum_next;
	logic [SUM_W-1:0]        sum_mag;
	logic [DVD_W-1:0]        div_dvd;
	logic [DV_W-1:0]         div_dvs;
	logic [DVD_W-1:0]        div_quo;
	logic [DV_W-1:0]         div_rem;
	div_ctl_t                div_ctl;
	div_sts_t                div_sts;
	logic [CHAN_W-1:0]       eff;
	logic [N_W-1:0]          nbk;
	logic                    active;
	logic                    frame_last;
	logic                    bucket_done;
	logic                    bucket_last;
	logic [Q15_W:0]          q_mag;
	logic signed [Q15_W-1:0] mixed;
	logic [N_W:0]            frac_sum;
	logic                    frac_wrap;
	logic [N_W+BUCKET_W-1:0] idx_ext;
	logic                    cfg_hit;
	logic                    s_hs;
	logic                    out_free;

	wpd_norm u_norm (
		.fmt  (fmt_q),
		.bits (s_tdata),
		.q15  (norm)
	);

	wpd_div #(
		.DVS_W (DV_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.sts       (div_sts),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// effective channel count and bucket count
	always_comb begin
		if (chan_q == '0) begin
			eff = CHAN_W'(1);
		end else if (chan_q > CHAN_W'(EFF_MAX)) begin
			eff = CHAN_W'(EFF_MAX);
		end else begin
			eff = chan_q;
		end
		nbk = (total_q < MAXP) ? total_q[N_W-1:0] : N_W'(MAX_POINTS);
	end

	// frame and bucket bookkeeping
	always_comb begin
		active      = (total_q != '0) && (frame_q < total_q);
		sum_next    = sum_q + SUM_W'(norm);
		frame_last  = ({1'b0, cnt_q} + 1'b1) >= {1'b0, eff};
		bucket_done = ({1'b0, frame_q} + 1'b1) >= {1'b0, end_q};
		bucket_last = ({1'b0, idx_q} + 1'b1) >= {1'b0, nbk};
		sum_mag     = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		q_mag       = div_quo[Q15_W:0];
		mixed       = sum_q[SUM_W-1] ? Q15_W'(-q_mag) : q_mag[Q15_W-1:0];
		frac_sum    = {1'b0, frac_q} + {1'b0, tr_q};
		frac_wrap   = frac_sum >= {1'b0, nbk};
		idx_ext     = (N_W + BUCKET_W)'(idx_q);
		cfg_hit     = cfg_valid && (cfg_index == REG_FORMAT || cfg_index == REG_CHANNELS ||
			cfg_index == REG_FRAMES);
		s_hs        = s_tvalid && s_tready;
		out_free    = !out_valid_q || m_tready;
	end

	// divider operands
	always_comb begin
		div_ctl.start = ((state_q == S_START) && (total_q != '0)) || (state_q == S_MIX);
		if (state_q == S_MIX) begin
			div_ctl.steps = DIV_STEP_W'(SUM_W);
			div_dvd       = {sum_mag, {(DVD_W - SUM_W){1'b0}}};
			div_dvs       = DV_W'(eff);
		end else begin
			div_ctl.steps = DIV_STEP_W'(DVD_W);
			div_dvd       = total_q;
			div_dvs       = DV_W'(nbk);
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_S16;
			chan_q  <= CHAN_W'(1);
			total_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FORMAT:   fmt_q   <= cfg_data[FMT_W-1:0];
				REG_CHANNELS: chan_q  <= cfg_data[CHAN_W-1:0];
				REG_FRAMES:   total_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// sequencer and clip state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			frame_q <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			peak_q  <= '0;
			pmag_q  <= '0;
		end else if (cfg_hit) begin
			state_q <= S_START;
			idx_q   <= '0;
			frame_q <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			peak_q  <= '0;
			pmag_q  <= '0;
		end else begin
			unique case (state_q)
				S_START: begin
					state_q <= (total_q != '0) ? S_SETUP : S_IDLE;
				end
				S_SETUP: begin
					if (div_sts.done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_hs && active) begin
						sum_q <= sum_next;
						if (frame_last) begin
							cnt_q   <= '0;
							state_q <= S_MIX;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_MIX: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_sts.done) begin
						state_q <= S_PEAK;
					end
				end
				S_PEAK: begin
					if (q_mag > pmag_q) begin
						peak_q <= mixed;
						pmag_q <= q_mag;
					end
					sum_q   <= '0;
					frame_q <= frame_q + 1'b1;
					state_q <= bucket_done ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (out_free) begin
						peak_q  <= '0;
						pmag_q  <= '0;
						idx_q   <= idx_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// bucket end tracking: quotient and fraction of (i+1)*total/n
	always_ff @(posedge clk) begin
		if (state_q == S_SETUP && div_sts.done) begin
			tq_q   <= div_quo;
			tr_q   <= div_rem[N_W-1:0];
			end_q  <= div_quo;
			frac_q <= div_rem[N_W-1:0];
		end else if (state_q == S_EMIT && out_free) begin
			if (frac_wrap) begin
				frac_q <= N_W'(frac_sum - {1'b0, nbk});
				end_q  <= end_q + tq_q + 1'b1;
			end else begin
				frac_q <= frac_sum[N_W-1:0];
				end_q  <= end_q + tq_q;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_peak_q <= peak_q;
			out_bnum_q <= idx_ext[BUCKET_W-1:0];
			out_last_q <= bucket_last;
		end
	end

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(32 - Q15_W - BUCKET_W){1'b0}}, out_bnum_q, out_peak_q};
	assign m_tlast   = out_last_q;

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// self-checking testbench for the waveform peak decimator, bucket peaks checked against a predictor
`timescale 1ns / 100ps

module tb_top;
	import wpd_pkg::*;

	localparam int MAX_POINTS       = 4096;
	localparam int MAX_CHANNELS     = 8;
	localparam int SETTLE_CYCLES    = 128;
	localparam int FULL_CLIP_FRAMES = 250;
	localparam int RANDOM_SAMPLES   = 520;
	localparam longint CYCLE_LIMIT = 2_000_000;

	// index past the register list, a write there must do nothing
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [15:0] peak;
		logic [11:0]        bucket;
		logic               closing;
	} peak_beat_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] data;
	} reg_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	waveform_peak_decimator_top #(
		.MAX_POINTS  (MAX_POINTS),
		.MAX_CHANNELS(MAX_CHANNELS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// predictor copy of registers and clip state
	logic [1:0]  clip_format;
	logic [3:0]  clip_chans;
	logic [31:0] clip_frames;
	int          bucket_num;
	logic [31:0] frames_done;
	logic [31:0] bucket_end;
	int          chans_seen;
	int          frame_sum;
	int          bucket_peak;

	peak_beat_t pending_peaks[$];
	peak_beat_t want;

	int     mismatches = 0;
	int     peaks_seen = 0;
	int     samples_mixed = 0;
	int     reg_writes = 0;
	int     burst_left = 0;
	int     steady_bursts = 0;
	int     ready_mode = 0;
	int     ready_run = 0;
	longint cycle_count = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int magnitude(int v);
		return v < 0 ? -v : v;
	endfunction

	function automatic int bucket_count();
		return (clip_frames < MAX_POINTS) ? int'(clip_frames) : MAX_POINTS;
	endfunction

	function automatic logic [31:0] bucket_end_at(int idx);
		int n;
		n = bucket_count();
		if (n == 0)
			return '0;
		return 32'((longint'(idx) + 1) * longint'(clip_frames) / n);
	endfunction

	function automatic int channels_in_use();
		if (clip_chans == 0)
			return 1;
		if (clip_chans > MAX_CHANNELS)
			return MAX_CHANNELS;
		return int'(clip_chans);
	endfunction

	function automatic void restart_clip();
		bucket_num  = 0;
		frames_done = '0;
		chans_seen  = 0;
		frame_sum   = 0;
		bucket_peak = 0;
		bucket_end  = bucket_end_at(0);
	endfunction

	// ieee single to q1.15, truncating, saturating at one
	function automatic int float_bits_to_q15(logic [31:0] bits);
		int expo;
		int mag;
		expo = int'(bits[30:23]);
		if (expo == 255 && bits[22:0] != '0)
			return 0;
		if (expo >= 127)
			return bits[31] ? -32768 : 32767;
		if (expo <= 111)
			return 0;
		mag = int'({1'b1, bits[22:0]} >> (135 - expo));
		return bits[31] ? -mag : mag;
	endfunction

	function automatic int sample_to_q15(logic [31:0] bits);
		case (clip_format)
			FMT_S16: return int'($signed(bits[15:0]));
			FMT_S8:  return int'($signed(bits[7:0])) * 256;
			FMT_U8:  return (int'(bits[7:0]) - 128) * 256;
			default: return float_bits_to_q15(bits);
		endcase
	endfunction

	// one accepted sample: accumulate the frame, track the bucket peak
	function automatic void mix_sample(logic [31:0] bits);
		int ch;
		int mag;
		int mixed;
		peak_beat_t beat;
		if (clip_frames == 0 || frames_done >= clip_frames)
			return;
		samples_mixed++;
		ch = channels_in_use();
		frame_sum += sample_to_q15(bits);
		chans_seen++;
		if (chans_seen < ch)
			return;
		mag = magnitude(frame_sum) / ch;
		mixed = frame_sum < 0 ? -mag : mag;
		frame_sum = 0;
		chans_seen = 0;
		// strictly larger only, so the first of equal magnitudes stays
		if (magnitude(mixed) > magnitude(bucket_peak))
			bucket_peak = mixed;
		frames_done++;
		if (frames_done < bucket_end)
			return;
		beat.peak    = bucket_peak[15:0];
		beat.bucket  = bucket_num[11:0];
		beat.closing = (bucket_num + 1 >= bucket_count());
		pending_peaks.push_back(beat);
		bucket_peak = 0;
		bucket_num++;
		bucket_end = bucket_end_at(bucket_num);
	endfunction

	function automatic void note_reg_write(reg_write_t w);
		reg_writes++;
		case (w.index)
			REG_FORMAT:   clip_format = w.data[1:0];
			REG_CHANNELS: clip_chans  = w.data[3:0];
			REG_FRAMES:   clip_frames = w.data;
			default:      return;
		endcase
		restart_clip();
	endfunction

	function automatic logic [31:0] random_sample(logic [1:0] fmt);
		logic [31:0] bits;
		int pick;
		bits = $urandom;
		pick = $urandom_range(0, 9);
		if (fmt == FMT_F32) begin
			// mostly exponents around the q1.15 range, some specials
			if (pick < 7) begin
				bits[30:23] = 8'($urandom_range(108, 128));
			end else if (pick == 7) begin
				bits[30:23] = 8'hFF;
				if (bits[0])
					bits[22:0] = '0;
			end else if (pick == 8) begin
				bits[30:23] = 8'h00;
			end
		end else if (pick == 0) begin
			bits[15:0] = bits[16] ? 16'h8000 : 16'h7FFF;
		end else if (pick == 1) begin
			bits[7:0] = bits[8] ? 8'h80 : 8'h7F;
		end
		return bits;
	endfunction

	// sample beat, sent in bursts with random gaps
	task automatic send_sample(logic [31:0] bits);
		int gap;
		if (burst_left == 0) begin
			if (steady_bursts > 0) begin
				steady_bursts--;
				gap = 0;
			end else begin
				gap = $urandom_range(1, 12);
				if ($urandom_range(0, 9) == 0)
					steady_bursts = $urandom_range(2, 8);
			end
			burst_left = $urandom_range(1, 20);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= bits;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		mix_sample(bits);
	endtask

	// register beats back to back, sample side held off
	task automatic apply_writes(reg_write_t writes[$]);
		s_tvalid <= 1'b0;
		foreach (writes[k]) begin
			cfg_valid <= 1'b1;
			cfg_index <= writes[k].index;
			cfg_data  <= writes[k].data;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			note_reg_write(writes[k]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic load_clip_setup(logic [1:0] fmt, logic [31:0] chans, logic [31:0] total);
		reg_write_t writes[$];
		writes.push_back('{REG_FORMAT, {30'b0, fmt}});
		writes.push_back('{REG_CHANNELS, chans});
		writes.push_back('{REG_FRAMES, total});
		apply_writes(writes);
	endtask

	// drain all pending peaks, then let the block settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_peaks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	// reset leaves an empty clip, samples must vanish
	task automatic test_empty_clip_after_reset();
		send_sample(32'h0000_7FFF);
		send_sample(32'hFFFF_8000);
		wait_idle();
	endtask

	// one frame per bucket shows each normalisation directly
	task automatic test_sample_formats();
		load_clip_setup(FMT_S16, 1, 2);
		send_sample(32'h0000_7FFF);
		send_sample(32'hFFFF_8000);
		wait_idle();
		load_clip_setup(FMT_S8, 1, 2);
		send_sample(32'hFFFF_FF7F);
		send_sample(32'h0000_0080);
		wait_idle();
		load_clip_setup(FMT_U8, 1, 2);
		send_sample(32'h0000_0000);
		send_sample(32'h1234_56FF);
		wait_idle();
		// infinity, minus one, nan, subnormal, below the lsb, just under one, minus one lsb
		load_clip_setup(FMT_F32, 1, 7);
		send_sample(32'h7F80_0000);
		send_sample(32'hBF80_0000);
		send_sample(32'h7FC0_0000);
		send_sample(32'h8000_0001);
		send_sample(32'h37FF_FFFF);
		send_sample(32'h3F7F_FFFF);
		send_sample(32'hB800_0000);
		wait_idle();
	endtask

	task automatic test_channel_mixing();
		reg_write_t writes[$];
		// negative sum truncates toward zero
		load_clip_setup(FMT_S16, 3, 1);
		send_sample(32'h0000_FFFB);
		send_sample(32'h0000_0000);
		send_sample(32'h0000_0000);
		wait_idle();
		// zero channels behaves as one
		load_clip_setup(FMT_S16, 32'hFFFF_FFF0, 1);
		send_sample(32'h0000_1234);
		wait_idle();
		// fifteen channels clamps to eight, widest sum
		load_clip_setup(FMT_S16, 15, 1);
		repeat (7) send_sample(32'h0000_8000);
		send_sample(32'h0000_7FFF);
		wait_idle();
		// write past the register list mid frame keeps the frame going
		load_clip_setup(FMT_S16, 2, 1);
		send_sample(32'h0000_0100);
		wait_idle();
		writes.push_back('{REG_UNUSED, 32'hFFFF_FFFF});
		apply_writes(writes);
		send_sample(32'h0000_0003);
		wait_idle();
	endtask

	task automatic test_bucket_edges();
		// two frames per bucket: tie keeps the first, all zero stays zero
		load_clip_setup(FMT_S16, 1, 8192);
		send_sample(32'h0000_0064);
		send_sample(32'h0000_FF9C);
		send_sample(32'h0000_FF38);
		send_sample(32'h0000_00C8);
		send_sample(32'h0000_0000);
		send_sample(32'h0000_0000);
		wait_idle();
		// largest clip, first bucket far beyond reach
		load_clip_setup(FMT_S8, 1, 32'hFFFF_FFFF);
		send_sample(32'h0000_007F);
		send_sample(32'h0000_0080);
		wait_idle();
	endtask

	// one frame per bucket up to the last bucket flag, plus a sample past the clip
	task automatic test_full_clip();
		logic [1:0] fmt;
		fmt = 2'($urandom_range(0, 3));
		load_clip_setup(fmt, 1, FULL_CLIP_FRAMES);
		repeat (FULL_CLIP_FRAMES + 1) send_sample(random_sample(fmt));
		wait_idle();
	endtask

	task automatic test_random_clips();
		int start_count;
		int pick;
		int frames;
		int ch;
		int extra;
		logic [31:0] total;
		logic [31:0] chan_data;
		reg_write_t writes[$];
		start_count = samples_mixed;
		while (samples_mixed - start_count < RANDOM_SAMPLES) begin
			writes.delete();
			pick = $urandom_range(0, 9);
			if (pick < 6)
				total = $urandom_range(1, 24);
			else if (pick < 8)
				total = $urandom_range(MAX_POINTS + 1, 3 * MAX_POINTS);
			else if (pick == 8)
				total = '0;
			else
				total = $urandom | 32'h0010_0000;
			if ($urandom_range(0, 1))
				writes.push_back('{REG_FORMAT, 32'($urandom)});
			if ($urandom_range(0, 1)) begin
				chan_data = $urandom;
				chan_data[3:0] = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(1, 8));
				writes.push_back('{REG_CHANNELS, chan_data});
			end
			if ($urandom_range(0, 7) == 0)
				writes.push_back('{REG_UNUSED, 32'($urandom)});
			writes.push_back('{REG_FRAMES, total});
			apply_writes(writes);

			ch = channels_in_use();
			if (pick < 6)
				frames = ($urandom_range(0, 4) == 0) ? $urandom_range(0, int'(total))
					: int'(total) + $urandom_range(0, 2);
			else if (pick < 8)
				frames = $urandom_range(10, 60);
			else
				frames = $urandom_range(3, 12);
			// sometimes leave a frame half filled before the next restart
			extra = (ch > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, ch - 1) : 0;
			repeat (frames * ch + extra) send_sample(random_sample(clip_format));
			wait_idle();
		end
	endtask

	// receiver stall pattern: runs of always ready, coin flips, heavy stalls and light stalls
	always @(posedge clk) begin
		if (ready_run == 0) begin
			ready_mode <= $urandom_range(0, 3);
			ready_run  <= $urandom_range(8, 80);
		end else begin
			ready_run <= ready_run - 1;
		end
		case (ready_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= 1'($urandom_range(0, 1));
			2:       m_tready <= ($urandom_range(0, 5) == 0);
			default: m_tready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// compare each peak beat with the oldest pending one
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_peaks.size() == 0) begin
				$error("peak beat with nothing pending: tdata %h tlast %b", m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = pending_peaks.pop_front();
				peaks_seen++;
				if (m_tdata[15:0] !== want.peak) begin
					$error("peak_value: expected %0d, actual %0d", want.peak,
						$signed(m_tdata[15:0]));
					mismatches++;
				end
				if (m_tdata[27:16] !== want.bucket) begin
					$error("bucket_number: expected %0d, actual %0d", want.bucket,
						m_tdata[27:16]);
					mismatches++;
				end
				if (m_tlast !== want.closing) begin
					$error("last_bucket: expected %b, actual %b", want.closing, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		clip_format = FMT_S16;
		clip_chans  = 4'd1;
		clip_frames = '0;
		restart_clip();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_clip_after_reset();
		test_sample_formats();
		test_channel_mixing();
		test_bucket_edges();
		test_full_clip();
		test_random_clips();
		wait_idle();

		$display("run covered %0d mixed samples in all four formats across %0d register writes",
			samples_mixed, reg_writes);
		$display("%0d bucket peaks checked, clips from empty to past %0d frames",
			peaks_seen, MAX_POINTS);
		if (mismatches == 0 && pending_peaks.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### sim.f
design/wpd_pkg.sv
design/wpd_norm.sv
design/wpd_div.sv
design/waveform_peak_decimator_top.sv
tb/sv/tb_top.sv
